FILE: hw/rtl/sorted_timer_event_queue_unit_macros.svh
// Assertion macros for the sorted timer event queue
`ifndef SORTED_TIMER_EVENT_QUEUE_UNIT_MACROS_SVH
`define SORTED_TIMER_EVENT_QUEUE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define STQ_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define STQ_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition");
`else
`define STQ_ASSERT_IMPL(label, clk, rst_n, prop)
`define STQ_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

FILE: hw/rtl/stq_pkg.sv
// Shared types and constants of the sorted timer event queue
`default_nettype none
package stq_pkg;
	localparam int EVENT_SLOTS = 16;
	localparam logic [1:0] ACT_SCHEDULE = 2'd0;
	localparam logic [1:0] ACT_REMOVE   = 2'd1;
	localparam logic [1:0] ACT_TICK     = 2'd2;
	localparam logic [1:0] ACT_CLEAR    = 2'd3;
	localparam logic [1:0] KIND_ACK   = 2'd0;
	localparam logic [1:0] KIND_FIRED = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;
	localparam logic [15:0] REBASE_AT  = 16'd10000;
	localparam logic [15:0] REBASE_SUB = 16'd5000;
	localparam logic [15:0] INCREMENT_RESET = 16'd3977;
	// result handed from the sequencer to the output register
	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic [3:0] ev;
		logic       imm;
		logic       chain;
		logic       ign;
		logic       last;
	} res_t;
endpackage
`default_nettype wire

FILE: hw/rtl/sorted_timer_event_queue_unit.sv
// Top level of the sorted timer event queue
//
// Command interface: raise start with action/event_id/delay/irq_mode; the
// transaction is taken when busy is low. busy rises at once and falls in the
// cycle in which the last result of the command is strobed.
// Results appear on the result ports for one cycle each, marked by
// result_valid; last flags the final result. The receiver cannot stall.
// Schedule, remove and elapsed-count reset give one acknowledge; a tick
// gives one fired result per due event in list order, then tick finished.
// State: one entry memory (due time, mode, next link) with a registered read;
// pending bits, head, counters and phase in flip-flops.
// A list walk visits each entry in two states (read, then compare or write):
// schedule walks past the entries due no later than the new one, remove walks
// to the event, tick walks the due entries and, on a rebase, the whole list.
// divider_increment is written by cfg_we/cfg_data; the user writes it only
// while idle, and the block itself does not enforce this.
// Reset: list empty, counters and phase zero, increment 3977. No clearing
// pass: memory entries are only read once linked.
`default_nettype none
`include "sorted_timer_event_queue_unit_macros.svh"
module sorted_timer_event_queue_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  action,
	input  wire logic [3:0]  event_id,
	input  wire logic [15:0] delay,
	input  wire logic        irq_mode,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_data,
	output logic             result_valid,
	output logic [1:0]       kind,
	output logic [3:0]       fired_event,
	output logic             fired_immediate,
	output logic             chain_legacy,
	output logic             ignored,
	output logic [31:0]      elapsed_ticks,
	output logic             last
);
	import stq_pkg::*;
	localparam int AW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
	localparam int LW = AW + 1;
	localparam int DW = 16 + 1 + LW;
	localparam logic [LW-1:0] NUL = LW'(EVENT_SLOTS);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SRD    = 4'd1; // schedule: issue read
	localparam logic [3:0] ST_SCMP   = 4'd2; // schedule: compare
	localparam logic [3:0] ST_SLINK  = 4'd3; // write link of previous entry
	localparam logic [3:0] ST_RRD    = 4'd4;
	localparam logic [3:0] ST_RCMP   = 4'd5;
	localparam logic [3:0] ST_TRD    = 4'd6;
	localparam logic [3:0] ST_TCMP   = 4'd7;
	localparam logic [3:0] ST_BRD    = 4'd8; // rebase walk
	localparam logic [3:0] ST_BWR    = 4'd9;
	localparam logic [3:0] ST_TEND   = 4'd10;
	localparam logic [3:0] ST_ACK    = 4'd11;

	logic [3:0]  state_q;
	logic [EVENT_SLOTS-1:0] pend_q;
	logic [LW-1:0] head_q, cur_q, prev_q;
	logic [13:0] cnt_q;
	logic [31:0] ticks_q;
	logic [15:0] phase_q, inc_q;
	logic [AW-1:0] id_q;
	logic [15:0] due_q;
	logic        imm_q, ign_q;
	logic [4:0]  n_q;
	res_t        res_q;
	// copy of the previous entry, rewritten with a new link
	logic [15:0]   pdue_q;
	logic          pimm_q;
	logic [LW-1:0] lnk_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [DW-1:0] wdata, rdata;
	logic [15:0]   r_due;
	logic          r_imm;
	logic [LW-1:0] r_nxt;
	logic [16:0]   dsum;
	logic [16:0]   psum;
	logic [15:0]   cnt16;

	stq_mem #(.AW(AW), .DW(DW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign r_due = rdata[DW-1 -: 16];
	assign r_imm = rdata[LW];
	assign r_nxt = rdata[LW-1:0];
	assign cnt16 = {2'b00, cnt_q};
	assign dsum  = {1'b0, delay} + {3'b000, cnt_q};
	assign psum  = {1'b0, phase_q} + {1'b0, inc_q};
	assign busy  = (state_q != ST_IDLE);
	assign raddr = cur_q[AW-1:0];

	// memory write port
	always_comb begin
		we = 1'b0;
		waddr = cur_q[AW-1:0];
		wdata = rdata;
		case (state_q)
			ST_SCMP: begin
				if (!(cur_q != NUL && n_q < 5'(EVENT_SLOTS) && r_due <= due_q)) begin
					we = 1'b1;
					waddr = id_q;
					wdata = {due_q, imm_q, cur_q};
				end
			end
			ST_SLINK: begin
				we = 1'b1;
				waddr = prev_q[AW-1:0];
				wdata = {pdue_q, pimm_q, lnk_q};
			end
			ST_BWR: begin
				we = 1'b1;
				wdata = {r_due - REBASE_SUB, r_imm, r_nxt};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= '0;
			head_q  <= NUL;
			cur_q   <= NUL;
			prev_q  <= NUL;
			cnt_q   <= '0;
			ticks_q <= '0;
			phase_q <= '0;
			inc_q   <= INCREMENT_RESET;
			n_q     <= '0;
			res_q   <= '0;
			ign_q   <= 1'b0;
		end else begin
			res_q <= '0;
			if (cfg_we) begin
				inc_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						id_q  <= event_id[AW-1:0];
						imm_q <= irq_mode;
						due_q <= dsum[16] ? 16'hFFFF : dsum[15:0];
						cur_q <= head_q;
						prev_q <= NUL;
						n_q   <= '0;
						ign_q <= 1'b0;
						case (action)
							ACT_SCHEDULE: begin
								if ({1'b0, event_id} >= 5'(EVENT_SLOTS) ||
								    pend_q[event_id[AW-1:0]]) begin
									ign_q <= 1'b1;
									state_q <= ST_ACK;
								end else begin
									state_q <= ST_SRD;
								end
							end
							ACT_REMOVE: begin
								if ({1'b0, event_id} < 5'(EVENT_SLOTS) &&
								    pend_q[event_id[AW-1:0]]) begin
									state_q <= ST_RRD;
								end else begin
									state_q <= ST_ACK;
								end
							end
							ACT_TICK: state_q <= ST_TRD;
							default: begin
								ticks_q <= '0;
								state_q <= ST_ACK;
							end
						endcase
					end
				end
				ST_SRD: state_q <= ST_SCMP;
				ST_SCMP: begin
					if (cur_q != NUL && n_q < 5'(EVENT_SLOTS) && r_due <= due_q) begin
						prev_q <= cur_q;
						pdue_q <= r_due;
						pimm_q <= r_imm;
						cur_q <= r_nxt;
						n_q <= n_q + 5'd1;
						state_q <= ST_SRD;
					end else begin
						pend_q[id_q] <= 1'b1;
						lnk_q <= LW'(id_q);
						if (prev_q == NUL) begin
							head_q <= LW'(id_q);
							state_q <= ST_ACK;
						end else begin
							state_q <= ST_SLINK;
						end
					end
				end
				ST_SLINK: state_q <= ST_ACK;
				ST_RRD: begin
					if (cur_q == NUL || n_q == 5'(EVENT_SLOTS)) begin
						pend_q[id_q] <= 1'b0;
						state_q <= ST_ACK;
					end else begin
						state_q <= ST_RCMP;
					end
				end
				ST_RCMP: begin
					if (cur_q[AW-1:0] == id_q) begin
						pend_q[id_q] <= 1'b0;
						if (prev_q == NUL) begin
							head_q <= r_nxt;
							state_q <= ST_ACK;
						end else begin
							// relink previous entry past the removed one
							lnk_q <= r_nxt;
							state_q <= ST_SLINK;
						end
					end else begin
						prev_q <= cur_q;
						pdue_q <= r_due;
						pimm_q <= r_imm;
						cur_q <= r_nxt;
						n_q <= n_q + 5'd1;
						state_q <= ST_RRD;
					end
				end
				ST_TRD: begin
					if (cur_q == NUL || n_q == 5'(EVENT_SLOTS)) begin
						state_q <= ST_TEND;
					end else begin
						state_q <= ST_TCMP;
					end
				end
				ST_TCMP: begin
					if (cnt16 >= r_due) begin
						pend_q[cur_q[AW-1:0]] <= 1'b0;
						head_q <= r_nxt;
						cur_q <= r_nxt;
						n_q <= n_q + 5'd1;
						res_q <= '{valid: 1'b1, kind: KIND_FIRED,
							ev: 4'(cur_q[AW-1:0]), imm: r_imm,
							chain: 1'b0, ign: 1'b0, last: 1'b0};
						state_q <= ST_TRD;
					end else begin
						state_q <= ST_TEND;
					end
				end
				ST_TEND: begin
					if (cnt16 >= REBASE_AT) begin
						cnt_q <= cnt_q - 14'(REBASE_SUB);
						cur_q <= head_q;
						n_q <= '0;
						state_q <= ST_BRD;
					end else begin
						cnt_q <= cnt_q + 14'd1;
						ticks_q <= ticks_q + 32'd1;
						phase_q <= psum[15:0];
						res_q <= '{valid: 1'b1, kind: KIND_DONE, ev: 4'd0, imm: 1'b0,
							chain: (psum == 17'd0) || psum[16], ign: 1'b0, last: 1'b1};
						state_q <= ST_IDLE;
					end
				end
				ST_BRD: begin
					if (cur_q == NUL || n_q == 5'(EVENT_SLOTS)) begin
						cnt_q <= cnt_q + 14'd1;
						ticks_q <= ticks_q + 32'd1;
						phase_q <= psum[15:0];
						res_q <= '{valid: 1'b1, kind: KIND_DONE, ev: 4'd0, imm: 1'b0,
							chain: (psum == 17'd0) || psum[16], ign: 1'b0, last: 1'b1};
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_BWR;
					end
				end
				ST_BWR: begin
					cur_q <= r_nxt;
					n_q <= n_q + 5'd1;
					state_q <= ST_BRD;
				end
				ST_ACK: begin
					res_q <= '{valid: 1'b1, kind: KIND_ACK, ev: 4'd0, imm: 1'b0,
						chain: 1'b0, ign: ign_q, last: 1'b1};
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid    = res_q.valid;
	assign kind            = res_q.kind;
	assign fired_event     = res_q.ev;
	assign fired_immediate = res_q.imm;
	assign chain_legacy    = res_q.chain;
	assign ignored         = res_q.ign;
	assign last            = res_q.last;
	// fired results go out before the tick count advances: show the count
	// the tick will leave behind
	assign elapsed_ticks   = ticks_q + {31'd0, res_q.kind == KIND_FIRED};

	`STQ_ASSERT_NEVER(a_busy_start, clk, arst_n, result_valid && last && $past(state_q) == ST_IDLE)
	`STQ_ASSERT_NEVER(a_idle_result, clk, arst_n, state_q == ST_IDLE && result_valid && !last)
	`STQ_ASSERT_IMPL(a_last_idle, clk, arst_n, (result_valid && last) |-> state_q == ST_IDLE)
endmodule
`default_nettype wire

FILE: hw/rtl/stq_mem.sv
// Entry memory of the event table: due time, mode and link per slot
`default_nettype none
module stq_mem #(
	parameter int AW = 4,
	parameter int DW = 22
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: dv/stq_checker.sv
// Checker for the sorted timer event queue: predicts results and compares them
`default_nettype none
module stq_checker
	import stq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [1:0]  action,
	input  wire logic [3:0]  event_id,
	input  wire logic [15:0] delay,
	input  wire logic        irq_mode,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_data,
	input  wire logic        result_valid,
	input  wire logic [1:0]  kind,
	input  wire logic [3:0]  fired_event,
	input  wire logic        fired_immediate,
	input  wire logic        chain_legacy,
	input  wire logic        ignored,
	input  wire logic [31:0] elapsed_ticks,
	input  wire logic        last,
	output int               errors,
	output int               outstanding
);
	localparam int SLOTS = 16;
	localparam int NIL   = SLOTS;

	typedef struct {
		logic [1:0]  kind;
		logic [3:0]  ev;
		logic        imm;
		logic        chain;
		logic        ign;
		logic [31:0] ticks;
		logic        last;
	} queue_result_t;

	queue_result_t due_results[$];

	logic [15:0] due_at [SLOTS];
	logic        imm_of [SLOTS];
	logic        armed  [SLOTS];
	int          link   [SLOTS];
	int          head;
	int          sched_cnt;
	logic [31:0] tick_total;
	logic [15:0] phase;
	logic [15:0] phase_inc;

	assign outstanding = due_results.size();

	task automatic push_result(input logic [1:0] k, input logic [3:0] ev, input logic imm,
			input logic chain, input logic ign);
		queue_result_t r;
		r.kind = k; r.ev = ev; r.imm = imm; r.chain = chain; r.ign = ign;
		r.ticks = 0; r.last = 0;
		due_results.push_back(r);
	endtask

	// advance the queue model by one transaction and queue its results
	task automatic predict_queue(input logic [1:0] act, input int id, input logic [15:0] dly,
			input logic imm);
		int cur, prev, first, n;
		int unsigned due;
		logic [16:0] sum;
		first = due_results.size();
		case (act)
			ACT_SCHEDULE: begin
				if (armed[id]) begin
					push_result(KIND_ACK, 0, 0, 0, 1);
				end else begin
					due = dly + sched_cnt;
					if (due > 65535) due = 65535;
					due_at[id] = due[15:0];
					imm_of[id] = imm;
					armed[id] = 1;
					cur = head; prev = NIL; n = 0;
					while (cur != NIL && n < SLOTS && due_at[cur] <= due[15:0]) begin
						prev = cur; cur = link[cur]; n++;
					end
					link[id] = cur;
					if (prev != NIL) link[prev] = id;
					else head = id;
					push_result(KIND_ACK, 0, 0, 0, 0);
				end
			end
			ACT_REMOVE: begin
				if (armed[id]) begin
					cur = head; prev = NIL; n = 0;
					while (cur != NIL && n < SLOTS && cur != id) begin
						prev = cur; cur = link[cur]; n++;
					end
					if (cur == id) begin
						if (prev != NIL) link[prev] = link[cur];
						else head = link[cur];
						link[cur] = NIL;
					end
					armed[id] = 0;
				end
				push_result(KIND_ACK, 0, 0, 0, 0);
			end
			ACT_CLEAR: begin
				tick_total = 0;
				push_result(KIND_ACK, 0, 0, 0, 0);
			end
			default: begin
				n = 0;
				while (head != NIL && n < SLOTS && sched_cnt >= due_at[head]) begin
					cur = head;
					head = link[cur];
					link[cur] = NIL;
					armed[cur] = 0;
					push_result(KIND_FIRED, cur[3:0], imm_of[cur], 0, 0);
					n++;
				end
				// rebase keeps due times inside 16 bits
				if (sched_cnt >= REBASE_AT) begin
					sched_cnt -= REBASE_SUB;
					cur = head; n = 0;
					while (cur != NIL && n < SLOTS) begin
						due_at[cur] = due_at[cur] - REBASE_SUB;
						cur = link[cur]; n++;
					end
				end
				sched_cnt = (sched_cnt + 1) & 16'h3fff;
				tick_total = tick_total + 1;
				sum = {1'b0, phase} + {1'b0, phase_inc};
				phase = sum[15:0];
				push_result(KIND_DONE, 0, 0, (sum == 0) || sum[16], 0);
			end
		endcase
		for (int j = first; j < due_results.size(); j++) due_results[j].ticks = tick_total;
		due_results[due_results.size() - 1].last = 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		queue_result_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				armed[i] = 0; link[i] = NIL; due_at[i] = 0; imm_of[i] = 0;
			end
			head = NIL; sched_cnt = 0; tick_total = 0; phase = 0;
			phase_inc = INCREMENT_RESET;
			errors = 0;
			due_results.delete();
		end else begin
			if (result_valid) begin
				if (due_results.size() == 0) begin
					$error("unexpected result transaction, kind %0d", kind);
					errors++;
				end else begin
					exp_r = due_results.pop_front();
					if (kind !== exp_r.kind) begin
						$error("kind: expected %0d, got %0d", exp_r.kind, kind); errors++;
					end
					if (fired_event !== exp_r.ev) begin
						$error("fired_event: expected %0d, got %0d", exp_r.ev, fired_event);
						errors++;
					end
					if (fired_immediate !== exp_r.imm) begin
						$error("fired_immediate: expected %0d, got %0d", exp_r.imm,
							fired_immediate);
						errors++;
					end
					if (chain_legacy !== exp_r.chain) begin
						$error("chain_legacy: expected %0d, got %0d", exp_r.chain, chain_legacy);
						errors++;
					end
					if (ignored !== exp_r.ign) begin
						$error("ignored: expected %0d, got %0d", exp_r.ign, ignored); errors++;
					end
					if (elapsed_ticks !== exp_r.ticks) begin
						$error("elapsed_ticks: expected %0d, got %0d", exp_r.ticks,
							elapsed_ticks);
						errors++;
					end
					if (last !== exp_r.last) begin
						$error("last: expected %0d, got %0d", exp_r.last, last); errors++;
					end
				end
			end
			if (cfg_we) phase_inc = cfg_data;
			if (start && !busy) predict_queue(action, int'(event_id), delay, irq_mode);
		end
	end
endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// Testbench top of the sorted timer event queue: stimulus and verdict
`default_nettype none
module tb_top;
	import stq_pkg::*;

	// generous bound: a few hundred commands and their list walks
	localparam int CYCLE_LIMIT = 100000;
	// drain margin after the last result, from the worst list walk
	localparam int DRAIN_CYCLES = 100;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  action;
	logic [3:0]  event_id;
	logic [15:0] delay;
	logic        irq_mode;
	logic        cfg_we;
	logic [15:0] cfg_data;
	logic        result_valid;
	logic [1:0]  kind;
	logic [3:0]  fired_event;
	logic        fired_immediate;
	logic        chain_legacy;
	logic        ignored;
	logic [31:0] elapsed_ticks;
	logic        last;
	int          errors;
	int          outstanding;
	int          cycles;
	bit          no_gaps;

	sorted_timer_event_queue_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .event_id(event_id), .delay(delay), .irq_mode(irq_mode),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.result_valid(result_valid), .kind(kind), .fired_event(fired_event),
		.fired_immediate(fired_immediate), .chain_legacy(chain_legacy),
		.ignored(ignored), .elapsed_ticks(elapsed_ticks), .last(last)
	);

	stq_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .event_id(event_id), .delay(delay), .irq_mode(irq_mode),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.result_valid(result_valid), .kind(kind), .fired_event(fired_event),
		.fired_immediate(fired_immediate), .chain_legacy(chain_legacy),
		.ignored(ignored), .elapsed_ticks(elapsed_ticks), .last(last),
		.errors(errors), .outstanding(outstanding)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// Offer one transaction and hold it until taken. busy is registered, so
	// the value seen at the falling edge holds through the next rising edge.
	// start is left high: the next call or a gap decides what follows.
	task automatic send(input logic [1:0] act, input logic [3:0] id, input logic [15:0] dly,
			input logic imm);
		start <= 1; action <= act; event_id <= id; delay <= dly; irq_mode <= imm;
		do @(negedge clk); while (busy);
		@(posedge clk);
		if (!no_gaps && $urandom_range(0, 99) < 25) begin
			start <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// wait for every queued result, then a margin, so the block is idle
	task automatic settle();
		start <= 0;
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_increment(input logic [15:0] value);
		settle();
		cfg_we <= 1; cfg_data <= value;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// mix of commands; delays mostly short so events actually fire
	task automatic random_item();
		int r;
		logic [15:0] dly;
		r = $urandom_range(0, 99);
		case ($urandom_range(0, 9))
			0: dly = 16'($urandom_range(0, 55535));
			1: dly = 16'd55535;
			default: dly = 16'($urandom_range(0, 40));
		endcase
		if (r < 38) send(ACT_SCHEDULE, 4'($urandom), dly, 1'($urandom));
		else if (r < 55) send(ACT_REMOVE, 4'($urandom), 16'($urandom_range(0, 55535)),
			1'($urandom));
		else if (r < 96) send(ACT_TICK, 4'($urandom), 16'($urandom_range(0, 55535)),
			1'($urandom));
		else send(ACT_CLEAR, 4'($urandom), 16'($urandom_range(0, 55535)), 1'($urandom));
	endtask

	initial begin
		logic [15:0] incs [6];
		arst_n = 0;
		start = 0; action = ACT_SCHEDULE; event_id = 0; delay = 0; irq_mode = 0;
		cfg_we = 0; cfg_data = 0; no_gaps = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: equal due times, already pending, idle remove, extremes
		send(ACT_SCHEDULE, 4'd0, 16'd0, 1'b1);
		send(ACT_SCHEDULE, 4'd0, 16'd7, 1'b0);
		send(ACT_SCHEDULE, 4'd1, 16'd0, 1'b0);
		send(ACT_SCHEDULE, 4'd15, 16'd55535, 1'b1);
		send(ACT_SCHEDULE, 4'd2, 16'd3, 1'b1);
		send(ACT_SCHEDULE, 4'd3, 16'd3, 1'b0);
		send(ACT_REMOVE, 4'd2, 16'd0, 1'b0);
		send(ACT_REMOVE, 4'd4, 16'hffff, 1'b1);
		send(ACT_TICK, 4'd0, 16'd0, 1'b0);
		send(ACT_TICK, 4'd0, 16'd0, 1'b0);
		send(ACT_TICK, 4'd0, 16'd0, 1'b0);
		send(ACT_TICK, 4'd0, 16'd0, 1'b0);
		send(ACT_CLEAR, 4'd9, 16'd1234, 1'b1);
		send(ACT_TICK, 4'd0, 16'd0, 1'b0);
		send(ACT_SCHEDULE, 4'd5, 16'd1, 1'b1);
		send(ACT_REMOVE, 4'd15, 16'd0, 1'b0);
		send(ACT_TICK, 4'd0, 16'd0, 1'b0);
		send(ACT_TICK, 4'd0, 16'd0, 1'b0);

		// random phases, each under a different divider step
		incs = '{16'd0, 16'hffff, 16'h8000, 16'd1, 16'($urandom), 16'd3977};
		foreach (incs[p]) begin
			write_increment(incs[p]);
			no_gaps = (p == 2);
			repeat (34) random_item();
		end
		no_gaps = 0;
		repeat (10) random_item();

		settle();
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
`default_nettype wire
